// ===== design/rtqe_pkg.sv =====
// ----------------------------------------------------------------------------
// rtqe_pkg: shared types and constants for the tag query engine
// Byte codes of the reader link, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package rtqe_pkg;

    // configuration port
    localparam int CFG_WIDTH = 16;
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ENABLE  = 2'd0;
    localparam t_cfg_idx CFG_TIMEOUT = 2'd1;
    localparam t_cfg_idx CFG_COMMAND = 2'd2;

    // register reset values
    localparam logic [15:0] TIMEOUT_DEFAULT = 16'd500;
    localparam logic [7:0]  COMMAND_DEFAULT = 8'h31;

    // command frame toward the reader
    localparam logic [7:0] CMD_PREAMBLE = 8'hBA;
    localparam logic [7:0] CMD_SIZE     = 8'h02;

    // reply frame from the reader
    localparam logic [7:0] RSP_PREAMBLE = 8'hBD;
    localparam logic [7:0] STATUS_OK    = 8'h00;
    localparam logic [7:0] CHK_SEED     = 8'h00;

    // uid prefix of a valid card
    localparam logic [7:0] UID_PREFIX_HI = 8'hE0;
    localparam logic [7:0] UID_PREFIX_LO = 8'h04;

    // fixed positions in the reply buffer
    localparam int IDX_STATUS    = 3;
    localparam int IDX_UID_FIRST = 4;
    localparam int IDX_UID_LAST  = 11;

    // walk phases over the reply buffer
    typedef logic [1:0] t_phase;
    localparam t_phase PH_CHK  = 2'd0;
    localparam t_phase PH_STAT = 2'd1;
    localparam t_phase PH_UID  = 2'd2;

endpackage

`default_nettype wire

// ===== design/rtqe_ram.sv =====
// ----------------------------------------------------------------------------
// rtqe_ram: generic single-port-write, single-port-read ram
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rtqe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/rfid_tag_query_engine.sv =====
// ----------------------------------------------------------------------------
// rfid_tag_query_engine: card reader poll engine
// Sends the get-tag-info command, gathers and checks the reply, holds the uid.
// ----------------------------------------------------------------------------
// Usage
//   Slave stream: one request per poll (read request, card sensor, optional
//   reader byte, millisecond tick). Master stream: one status result per
//   poll, or four command bytes when the command goes out, tlast on the final.
//   Configuration writes go through the write port; the user is to make them
//   only while the block is idle, and the block itself does not enforce it.
//   A poll without a reader byte passes through the hold state to the output
//   register. A poll with a byte is written into the reply ram, then the ram
//   is walked one entry a cycle through its single read port: up to len + 2
//   entries for the checksum, then status and 8 uid bytes.
//   One poll is worked on at a time; the next request is taken while the
//   previous results are still being delivered.
// Reset
//   Synchronous, active low. Config and control registers take defaults; the
//   reply buffer reads as zeros through per-entry valid bits, no clearing pass.
// Stall
//   When the receiver holds tready low, results wait in the output register
//   and a finished poll waits behind them; tready on the input drops then.
// ----------------------------------------------------------------------------
`default_nettype none

module rfid_tag_query_engine #(
    parameter int BUFFER_DEPTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration write port
    input  wire logic                          i_cfg_wen,
    input  wire rtqe_pkg::t_cfg_idx            i_cfg_idx,
    input  wire logic [rtqe_pkg::CFG_WIDTH-1:0] i_cfg_wdata,
    // poll requests
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [0] read_request, [1] card_sensor_low, [2] rx_valid, [10:3] rx_data,
    // [11] ms_tick, [15:12] zero
    input  wire logic [15:0]                   i_s_axis_tdata,
    // results
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // [0] tx_valid, [8:1] tx_byte, [9] card_valid, [73:10] uid_value,
    // [74] read_pending, [79:75] zero
    output logic [79:0]                        o_m_axis_tdata,
    output logic                               o_m_axis_tlast
);

    import rtqe_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;
    localparam logic [1:0] S_HOLD  = 2'd3;

    // configuration
    logic        r_en;
    logic [15:0] r_tmo;
    logic [7:0]  r_cmd;

    // engine state
    logic [1:0]        r_state, n_state;
    logic              r_pend, n_pend;
    logic              r_sent, n_sent;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [63:0]       r_uid_store, n_uid_store;
    logic              r_card, n_card;
    logic [15:0]       r_wait, n_wait;
    logic              r_send, n_send;
    logic [BUFFER_DEPTH-1:0] r_vld, n_vld;

    // walk registers
    t_phase      r_ph, n_ph;
    logic [AW-1:0] r_idx, n_idx;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_chk, n_chk;
    logic [63:0] r_uid, n_uid;
    logic        r_rd_vld;

    // output stage
    logic        r_ovld, n_ovld;
    logic        r_osend, n_osend;
    logic [1:0]  r_ok, n_ok;
    logic [7:0]  r_ocmd, n_ocmd;
    logic        r_ocard, n_ocard;
    logic [63:0] r_ouid, n_ouid;
    logic        r_opend, n_opend;

    // ram port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_q;

    // request fields
    logic       f_req, f_sens, f_rxv, f_tick;
    logic [7:0] f_rx;
    logic       in_acc, out_acc;

    // helpers
    logic [15:0]   s_wait;
    logic          s_pend;
    logic [AW-1:0] s_pos;
    logic [7:0]    s_d;
    logic [7:0]    s_len_eff;
    logic [63:0]   s_uid_next;
    logic [7:0]    s_txb;

    assign f_req  = i_s_axis_tdata[0];
    assign f_sens = i_s_axis_tdata[1];
    assign f_rxv  = i_s_axis_tdata[2];
    assign f_rx   = i_s_axis_tdata[10:3];
    assign f_tick = i_s_axis_tdata[11];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc = r_ovld && i_m_axis_tready;

    // reply buffer
    rtqe_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (f_rx),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // poll-time values
    assign s_wait = (f_tick && (r_wait != 16'hFFFF)) ? r_wait + 16'd1 : r_wait;
    assign s_pend = r_pend | f_req;
    assign s_pos  = (r_cnt >= CW'(BUFFER_DEPTH)) ? '0 : r_cnt[AW-1:0];
    assign ram_waddr = s_pos;

    // walk-time values, never-written entries read as zero
    assign s_d        = r_rd_vld ? ram_q : 8'h00;
    assign s_len_eff  = (r_idx == AW'(1)) ? s_d : r_len;
    assign s_uid_next = {s_d, r_uid[63:8]};

    // next-state logic
    always_comb begin
        n_state     = r_state;
        n_pend      = r_pend;
        n_sent      = r_sent;
        n_cnt       = r_cnt;
        n_uid_store = r_uid_store;
        n_card      = r_card;
        n_wait      = r_wait;
        n_send      = r_send;
        n_vld       = r_vld;
        n_ph        = r_ph;
        n_idx       = r_idx;
        n_len       = r_len;
        n_chk       = r_chk;
        n_uid       = r_uid;
        n_ovld      = r_ovld;
        n_osend     = r_osend;
        n_ok        = r_ok;
        n_ocmd      = r_ocmd;
        n_ocard     = r_ocard;
        n_ouid      = r_ouid;
        n_opend     = r_opend;
        ram_we      = 1'b0;
        ram_raddr   = r_idx;

        case (r_state)
            // take a poll and handle everything short of the reply walk
            S_IDLE: begin
                if (in_acc) begin
                    n_wait  = s_wait;
                    n_pend  = s_pend;
                    n_send  = 1'b0;
                    n_state = S_HOLD;
                    if (r_en && s_pend) begin
                        if (f_sens) begin
                            if (!r_sent) begin
                                n_send = 1'b1;
                                n_cnt  = '0;
                                n_sent = 1'b1;
                                n_wait = 16'd0;
                            end else if (f_rxv) begin
                                ram_we       = 1'b1;
                                n_vld[s_pos] = 1'b1;
                                n_cnt        = CW'(s_pos) + CW'(1);
                                n_state      = S_START;
                            end else if (s_wait > r_tmo) begin
                                n_sent = 1'b0;
                            end
                        end else begin
                            n_card = 1'b0;
                            n_sent = 1'b0;
                            n_pend = 1'b0;
                        end
                    end
                end
            end
            // first read of the walk, after the byte write has landed
            S_START: begin
                n_idx     = '0;
                n_ph      = PH_CHK;
                n_chk     = CHK_SEED;
                ram_raddr = '0;
                n_state   = S_WALK;
            end
            // one buffer entry per cycle
            S_WALK: begin
                case (r_ph)
                    PH_CHK: begin
                        if (r_idx == '0) begin
                            if (s_d != RSP_PREAMBLE) begin
                                n_cnt   = '0;
                                n_state = S_HOLD;
                            end else if (r_cnt <= CW'(2)) begin
                                n_state = S_HOLD;
                            end else begin
                                n_chk = r_chk ^ s_d;
                                n_idx = r_idx + AW'(1);
                            end
                        end else if ((r_idx == AW'(1)) &&
                                     (({2'b00, s_d} + 10'd2) > 10'(BUFFER_DEPTH))) begin
                            n_cnt   = '0;
                            n_state = S_HOLD;
                        end else if ((r_idx == AW'(1)) &&
                                     (10'(r_cnt) < ({2'b00, s_d} + 10'd2))) begin
                            n_state = S_HOLD;
                        end else if (9'(r_idx) == ({1'b0, s_len_eff} + 9'd1)) begin
                            // checksum byte
                            if (r_chk != s_d) begin
                                n_sent  = 1'b0;
                                n_state = S_HOLD;
                            end else begin
                                n_ph  = PH_STAT;
                                n_idx = AW'(IDX_STATUS);
                            end
                        end else begin
                            n_len = s_len_eff;
                            n_chk = r_chk ^ s_d;
                            n_idx = r_idx + AW'(1);
                        end
                    end
                    PH_STAT: begin
                        if (s_d != STATUS_OK) begin
                            n_sent  = 1'b0;
                            n_state = S_HOLD;
                        end else begin
                            n_ph  = PH_UID;
                            n_idx = AW'(IDX_UID_FIRST);
                        end
                    end
                    PH_UID: begin
                        n_uid = s_uid_next;
                        if (r_idx == AW'(IDX_UID_LAST)) begin
                            n_uid_store = s_uid_next;
                            n_card      = (s_uid_next[63:56] == UID_PREFIX_HI) &&
                                          (s_uid_next[55:48] == UID_PREFIX_LO);
                            n_pend      = 1'b0;
                            n_state     = S_HOLD;
                        end else begin
                            n_idx = r_idx + AW'(1);
                        end
                    end
                    default: begin
                        n_state = S_HOLD;
                    end
                endcase
                ram_raddr = n_idx;
            end
            // hand the finished poll to the output stage
            S_HOLD: begin
                if (!r_ovld) begin
                    n_ovld  = 1'b1;
                    n_osend = r_send;
                    n_ok    = 2'd0;
                    n_ocmd  = r_cmd;
                    n_ocard = r_card;
                    n_ouid  = r_uid_store;
                    n_opend = r_pend;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // output stage drains one result per output handshake
        if (out_acc) begin
            if (r_osend && (r_ok != 2'd3)) begin
                n_ok = r_ok + 2'd1;
            end else begin
                n_ovld = 1'b0;
            end
        end
    end

    // command byte in send order
    always_comb begin
        case (r_ok)
            2'd0:    s_txb = CMD_PREAMBLE;
            2'd1:    s_txb = CMD_SIZE;
            2'd2:    s_txb = r_ocmd;
            default: s_txb = CMD_PREAMBLE ^ CMD_SIZE ^ r_ocmd;
        endcase
    end

    assign o_m_axis_tvalid = r_ovld;
    assign o_m_axis_tlast  = !r_osend || (r_ok == 2'd3);
    assign o_m_axis_tdata  = {5'b00000, r_opend, r_ouid, r_ocard,
                              (r_osend ? s_txb : 8'h00), r_osend};

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en  <= 1'b0;
            r_tmo <= TIMEOUT_DEFAULT;
            r_cmd <= COMMAND_DEFAULT;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                CFG_ENABLE:  r_en  <= i_cfg_wdata[0];
                CFG_TIMEOUT: r_tmo <= i_cfg_wdata[15:0];
                CFG_COMMAND: r_cmd <= i_cfg_wdata[7:0];
                default:     r_en  <= r_en;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_sent      <= 1'b0;
            r_cnt       <= '0;
            r_uid_store <= 64'd0;
            r_card      <= 1'b0;
            r_wait      <= 16'd0;
            r_send      <= 1'b0;
            r_vld       <= '0;
            r_ovld      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_sent      <= n_sent;
            r_cnt       <= n_cnt;
            r_uid_store <= n_uid_store;
            r_card      <= n_card;
            r_wait      <= n_wait;
            r_send      <= n_send;
            r_vld       <= n_vld;
            r_ovld      <= n_ovld;
        end
    end

    // walk and output payload
    always_ff @(posedge i_clk) begin
        r_ph     <= n_ph;
        r_idx    <= n_idx;
        r_len    <= n_len;
        r_chk    <= n_chk;
        r_uid    <= n_uid;
        r_rd_vld <= r_vld[ram_raddr];
        r_osend  <= n_osend;
        r_ok     <= n_ok;
        r_ocmd   <= n_ocmd;
        r_ocard  <= n_ocard;
        r_ouid   <= n_ouid;
        r_opend  <= n_opend;
    end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the card reader poll engine
// Polls go in on the slave stream. A cycle-free predictor works out the
// status result or the four command bytes of every accepted poll, and a
// monitor compares each delivered result field by field in order. Directed
// tests walk the reply framing and error cases, then random reads follow.
// ----------------------------------------------------------------------------
module tb;

    import rtqe_pkg::*;

    localparam int BUF_DEPTH     = 32;
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_POLLS  = 150;
    localparam int GAP_MAX       = 16;

    // one delivered result of a poll
    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        last;
        logic        card_valid;
        logic [63:0] uid;
        logic        pending;
    } t_poll_result;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_wen       = 1'b0;
    t_cfg_idx             i_cfg_idx       = CFG_ENABLE;
    logic [CFG_WIDTH-1:0] i_cfg_wdata     = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [15:0]          i_s_axis_tdata  = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [79:0]          o_m_axis_tdata;
    logic                 o_m_axis_tlast;

    // results still owed by the block, oldest first
    t_poll_result poll_out_q [$];
    int           mismatch_count = 0;
    int           polls_sent     = 0;
    int           src_gap_max    = GAP_MAX;
    int           sink_gap_max   = GAP_MAX;
    int           sink_hold      = 0;

    // predicted register and reader state
    logic        rd_enable   = 1'b0;
    logic [15:0] rd_timeout  = TIMEOUT_DEFAULT;
    logic [7:0]  rd_command  = COMMAND_DEFAULT;
    logic        rd_pending  = 1'b0;
    logic        rd_cmd_sent = 1'b0;
    int          rd_count    = 0;
    logic [7:0]  rd_buf [BUF_DEPTH] = '{default: 8'h00};
    logic [63:0] rd_uid      = '0;
    logic        rd_card     = 1'b0;
    logic [15:0] rd_wait     = '0;

    rfid_tag_query_engine #(
        .BUFFER_DEPTH (BUF_DEPTH)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [7:0] rand_byte();
        rand_byte = 8'($urandom_range(255, 0));
    endfunction

    // store one reply byte and check the packet once complete
    task automatic absorb_reply_byte(input logic [7:0] b);
        int         len;
        int         i;
        logic [7:0] chk;
        if (rd_count >= BUF_DEPTH)
            rd_count = 0;
        rd_buf[rd_count] = b;
        rd_count++;
        if (rd_buf[0] != RSP_PREAMBLE)
            rd_count = 0;
        if (rd_count > 2) begin
            len = int'(rd_buf[1]);
            if (len + 2 > BUF_DEPTH) begin
                rd_count = 0;
            end else if (rd_count >= len + 2) begin
                chk = CHK_SEED;
                for (i = 0; i <= len; i++)
                    chk ^= rd_buf[i];
                if (chk != rd_buf[len + 1] || rd_buf[IDX_STATUS] != STATUS_OK) begin
                    rd_cmd_sent = 1'b0;
                end else begin
                    // uid is held with the last buffer byte on top
                    rd_uid = '0;
                    for (i = IDX_UID_LAST; i >= IDX_UID_FIRST; i--)
                        rd_uid = {rd_uid[55:0], rd_buf[i]};
                    rd_card = (rd_buf[IDX_UID_LAST] == UID_PREFIX_HI) &&
                              (rd_buf[IDX_UID_LAST - 1] == UID_PREFIX_LO);
                    rd_pending = 1'b0;
                end
            end
        end
    endtask

    // update reader state for one accepted poll and queue its results
    task automatic compute_poll_outputs(input logic req, input logic sensor,
                                        input logic rxv, input logic [7:0] rxd,
                                        input logic tick);
        logic [7:0]   frame [4];
        int           n;
        int           k;
        t_poll_result r;
        n = 0;
        if (tick && rd_wait != 16'hFFFF)
            rd_wait++;
        if (req)
            rd_pending = 1'b1;
        if (rd_enable && rd_pending) begin
            if (sensor) begin
                if (!rd_cmd_sent) begin
                    frame[0]    = CMD_PREAMBLE;
                    frame[1]    = CMD_SIZE;
                    frame[2]    = rd_command;
                    frame[3]    = CMD_PREAMBLE ^ CMD_SIZE ^ rd_command;
                    n           = 4;
                    rd_count    = 0;
                    rd_cmd_sent = 1'b1;
                    rd_wait     = '0;
                end else if (rxv) begin
                    absorb_reply_byte(rxd);
                end else if (rd_wait > rd_timeout) begin
                    rd_cmd_sent = 1'b0;
                end
            end else begin
                // card left the field
                rd_card     = 1'b0;
                rd_cmd_sent = 1'b0;
                rd_pending  = 1'b0;
            end
        end
        r.card_valid = rd_card;
        r.uid        = rd_uid;
        r.pending    = rd_pending;
        if (n == 0) begin
            r.tx_valid = 1'b0;
            r.tx_byte  = 8'h00;
            r.last     = 1'b1;
            poll_out_q.push_back(r);
        end else begin
            for (k = 0; k < n; k++) begin
                r.tx_valid = 1'b1;
                r.tx_byte  = frame[k];
                r.last     = (k == n - 1);
                poll_out_q.push_back(r);
            end
        end
    endtask

    // offer one poll request and wait until it is taken
    task automatic send_poll(input logic req, input logic sensor, input logic rxv,
                             input logic [7:0] rxd, input logic tick);
        int gap;
        gap = (src_gap_max > 0) ? $urandom_range(src_gap_max, 0) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0000, tick, rxd, rxv, sensor, req};
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        compute_poll_outputs(req, sensor, rxv, rxd, tick);
        polls_sent++;
    endtask

    // stop offering and wait for every owed result plus the walk latency
    task automatic settle_idle();
        i_s_axis_tvalid <= 1'b0;
        while (poll_out_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] value);
        i_cfg_wen   <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_ENABLE:  rd_enable  = value[0];
            CFG_TIMEOUT: rd_timeout = value;
            CFG_COMMAND: rd_command = value[7:0];
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    // result monitor with random and forced hold-offs
    initial begin : result_monitor
        int           stall;
        t_poll_result want;
        wait (i_rst_n === 1'b1);
        forever begin
            if (sink_hold > 0) begin
                stall     = sink_hold;
                sink_hold = 0;
            end else begin
                stall = (sink_gap_max > 0) ? $urandom_range(sink_gap_max, 0) : 0;
            end
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (o_m_axis_tvalid !== 1'b1);
            if (poll_out_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with none expected, expected none actual %h",
                         $time, o_m_axis_tdata);
            end else begin
                want = poll_out_q.pop_front();
                check_field("tx_valid", 64'(want.tx_valid), 64'(o_m_axis_tdata[0]));
                check_field("tx_byte", 64'(want.tx_byte), 64'(o_m_axis_tdata[8:1]));
                check_field("last", 64'(want.last), 64'(o_m_axis_tlast));
                check_field("card_valid", 64'(want.card_valid), 64'(o_m_axis_tdata[9]));
                check_field("uid_value", want.uid, o_m_axis_tdata[73:10]);
                check_field("read_pending", 64'(want.pending), 64'(o_m_axis_tdata[74]));
            end
        end
    end

    // reader still disabled after reset: request latches, bytes dropped
    task automatic test_disabled_poll();
        send_poll(1'b1, 1'b1, 1'b1, 8'hFF, 1'b1);
        send_poll(1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
        settle_idle();
    endtask

    // command out, zero timeout, lost preamble, oversized and short replies
    task automatic test_reply_framing();
        write_reg(CFG_ENABLE, 16'h0001);
        write_reg(CFG_COMMAND, 16'h0000);
        write_reg(CFG_TIMEOUT, 16'h0000);
        // byte on the command poll is dropped
        send_poll(1'b0, 1'b1, 1'b1, RSP_PREAMBLE, 1'b0);
        // timeout and resend
        send_poll(1'b0, 1'b1, 1'b0, 8'hFF, 1'b1);
        send_poll(1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
        // byte without preamble
        send_poll(1'b0, 1'b1, 1'b1, 8'h55, 1'b0);
        // length too large for the buffer
        send_poll(1'b0, 1'b1, 1'b1, RSP_PREAMBLE, 1'b0);
        send_poll(1'b0, 1'b1, 1'b1, 8'h1F, 1'b0);
        // short reply, uid taken from the cleared buffer
        send_poll(1'b0, 1'b1, 1'b1, RSP_PREAMBLE, 1'b0);
        send_poll(1'b0, 1'b1, 1'b1, 8'h03, 1'b0);
        send_poll(1'b0, 1'b1, 1'b1, 8'h00, 1'b0);
        send_poll(1'b0, 1'b1, 1'b1, STATUS_OK, 1'b0);
        send_poll(1'b0, 1'b1, 1'b1, RSP_PREAMBLE ^ 8'h03, 1'b0);
        // byte while idle, then request with no card
        send_poll(1'b0, 1'b1, 1'b1, RSP_PREAMBLE, 1'b1);
        send_poll(1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
        settle_idle();
    endtask

    // checksum error and error status both force a resend
    task automatic test_reply_errors();
        write_reg(CFG_COMMAND, 16'h00FF);
        write_reg(CFG_TIMEOUT, 16'hFFFF);
        send_poll(1'b1, 1'b1, 1'b0, 8'h00, 1'b1);
        send_poll(1'b0, 1'b1, 1'b1, RSP_PREAMBLE, 1'b0);
        send_poll(1'b0, 1'b1, 1'b1, 8'h01, 1'b0);
        send_poll(1'b0, 1'b1, 1'b1, 8'h00, 1'b0);
        send_poll(1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
        send_poll(1'b0, 1'b1, 1'b1, RSP_PREAMBLE, 1'b0);
        send_poll(1'b0, 1'b1, 1'b1, 8'h03, 1'b0);
        send_poll(1'b0, 1'b1, 1'b1, 8'h31, 1'b0);
        send_poll(1'b0, 1'b1, 1'b1, 8'h01, 1'b0);
        send_poll(1'b0, 1'b1, 1'b1, RSP_PREAMBLE ^ 8'h03 ^ 8'h31 ^ 8'h01, 1'b0);
        send_poll(1'b0, 1'b1, 1'b0, 8'h00, 1'b1);
        send_poll(1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
        settle_idle();
    endtask

    // receiver holds off while polls keep coming until the input stalls
    task automatic test_output_stall();
        src_gap_max = 0;
        sink_hold   = 400;
        send_poll(1'b1, 1'b1, 1'b0, rand_byte(), 1'b0);
        repeat (20) send_poll(1'b0, 1'b1, 1'b0, rand_byte(), 1'b0);
        send_poll(1'b0, 1'b0, 1'b0, rand_byte(), 1'b0);
        settle_idle();
        src_gap_max = GAP_MAX;
    endtask

    // millisecond count runs while disabled, then times out once enabled
    task automatic test_wait_count();
        write_reg(CFG_TIMEOUT, 16'h0004);
        send_poll(1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
        settle_idle();
        write_reg(CFG_ENABLE, 16'h0000);
        src_gap_max  = 0;
        sink_gap_max = 0;
        repeat (6) send_poll(1'b0, 1'b1, 1'b0, rand_byte(), 1'b1);
        settle_idle();
        write_reg(CFG_ENABLE, 16'h0001);
        send_poll(1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
        send_poll(1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
        send_poll(1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
        settle_idle();
        src_gap_max  = GAP_MAX;
        sink_gap_max = GAP_MAX;
    endtask

    // random reads: mostly well-formed replies with random content
    task automatic test_random_reads();
        logic [7:0] fr [$];
        logic [7:0] chk;
        int         kind;
        int         len;
        int         i;
        int         start;
        start = polls_sent;
        write_reg(CFG_ENABLE, 16'h0001);
        write_reg(CFG_TIMEOUT, TIMEOUT_DEFAULT);
        write_reg(CFG_COMMAND, {8'h00, COMMAND_DEFAULT});
        while (polls_sent - start < RANDOM_POLLS) begin
            // occasional reconfiguration between reads
            if ($urandom_range(3, 0) == 0) begin
                settle_idle();
                case ($urandom_range(3, 0))
                    0: write_reg(CFG_TIMEOUT, 16'h0000);
                    1: write_reg(CFG_TIMEOUT, 16'($urandom_range(8, 1)));
                    2: write_reg(CFG_TIMEOUT, 16'($urandom_range(40, 9)));
                    default: write_reg(CFG_TIMEOUT, TIMEOUT_DEFAULT);
                endcase
                write_reg(CFG_COMMAND, {8'h00, rand_byte()});
                write_reg(CFG_ENABLE, {15'd0, $urandom_range(7, 0) != 0});
                src_gap_max  = $urandom_range(1, 0) ? GAP_MAX : 0;
                sink_gap_max = $urandom_range(1, 0) ? GAP_MAX : 0;
            end
            send_poll(1'b1, $urandom_range(15, 0) != 0, 1'b0, rand_byte(),
                      $urandom_range(3, 0) == 0);
            // build the reply
            fr.delete();
            kind = $urandom_range(9, 0);
            if (kind == 9) begin
                // header of a reply too long for the buffer
                fr.push_back(RSP_PREAMBLE);
                fr.push_back(8'($urandom_range(255, BUF_DEPTH - 1)));
            end else begin
                len = (kind == 8) ? $urandom_range(10, 2) : IDX_UID_LAST;
                fr.push_back(RSP_PREAMBLE);
                fr.push_back(8'(len));
                for (i = 2; i <= len; i++)
                    fr.push_back(rand_byte());
                if (len >= IDX_STATUS)
                    fr[IDX_STATUS] = STATUS_OK;
                if (kind == 7)
                    fr[IDX_STATUS] = 8'($urandom_range(255, 1));
                if (kind <= 3) begin
                    fr[IDX_UID_LAST]     = UID_PREFIX_HI;
                    fr[IDX_UID_LAST - 1] = UID_PREFIX_LO;
                end
                chk = CHK_SEED;
                for (i = 0; i <= len; i++)
                    chk ^= fr[i];
                if (kind == 6)
                    chk ^= 8'h01 << $urandom_range(7, 0);
                fr.push_back(chk);
            end
            // stray byte ahead of the reply
            if ($urandom_range(4, 0) == 0)
                fr.push_front(rand_byte());
            foreach (fr[j]) begin
                if ($urandom_range(4, 0) == 0)
                    send_poll($urandom_range(7, 0) == 0, 1'b1, 1'b0, rand_byte(),
                              $urandom_range(3, 0) == 0);
                send_poll($urandom_range(15, 0) == 0, $urandom_range(39, 0) != 0, 1'b1,
                          fr[j], $urandom_range(3, 0) == 0);
            end
        end
        settle_idle();
    endtask

    // test sequence
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_disabled_poll();
        test_reply_framing();
        test_reply_errors();
        test_output_stall();
        test_wait_count();
        test_random_reads();
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // run limit
    initial begin
        #40_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
design/rtqe_pkg.sv
design/rtqe_ram.sv
design/rfid_tag_query_engine.sv
dv/tb.sv
